[src/mnep_pkg.sv]
// Package for the MIDI note event parser: status codes, event kinds and helpers.
`timescale 1ns / 1ps

package mnep_pkg;

    // Event kinds on the result channel
    localparam logic [1:0] EV_NOTE_OFF      = 2'd0;
    localparam logic [1:0] EV_NOTE_ON       = 2'd1;
    localparam logic [1:0] EV_ALL_NOTES_OFF = 2'd2;

    // Status bytes and message types
    localparam logic [7:0] ST_SYSEX_START   = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END     = 8'hF7;
    localparam logic [7:0] ST_REALTIME_LO   = 8'hF8;
    localparam logic [7:0] ST_TYPE_MASK     = 8'hF0;
    localparam logic [7:0] ST_CHAN_MASK     = 8'h0F;
    localparam logic [7:0] TY_NOTE_OFF      = 8'h80;
    localparam logic [7:0] TY_NOTE_ON       = 8'h90;
    localparam logic [7:0] TY_CONTROL       = 8'hB0;
    localparam logic [7:0] TY_PROG_CHANGE   = 8'hC0;
    localparam logic [7:0] TY_CHAN_PRESSURE = 8'hD0;
    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'h7B;

    // Program change and channel pressure carry a single data byte
    function automatic logic single_data_kind(input logic [7:0] status);
        logic [7:0] ty;
        ty = status & ST_TYPE_MASK;
        return (ty == TY_PROG_CHANGE) || (ty == TY_CHAN_PRESSURE);
    endfunction

endpackage

[src/midi_note_event_parser.sv]
// MIDI running-status parser giving note-off, note-on and all-notes-off events.
//
// Usage:
//   Input channel: one received MIDI byte per item on i_rx_byte, handshake
//   i_in_valid / o_in_ready. Result channel: o_event_kind, o_channel, o_note,
//   o_velocity, handshake o_out_valid / i_out_ready. A byte gives at most one
//   result; most bytes give none.
//   Path: a byte is accepted into the input register and parsed from it,
//   and its result (if any) is offered from the result register.
//   Throughput: one byte per cycle while the receiver takes results. The
//   parse state (phase, running status, current status, first data byte,
//   SysEx flag) is updated in the same cycle as the result register loads.
//   Stalls: if a result waits and i_out_ready is low, the input register
//   holds its byte and o_in_ready drops once that register is also full.
//   Reset: synchronous, active low on i_rst_n; both stages empty, parser
//   waiting for a status byte, no running status, not in SysEx.
`timescale 1ns / 1ps

module midi_note_event_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_event_kind,
    output logic [3:0] o_channel,
    output logic [6:0] o_note,
    output logic [6:0] o_velocity
);

    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_DATA1  = 2'd1,
        PH_DATA2  = 2'd2
    } t_phase;

    // Input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Parse state
    t_phase     r_phase,   n_phase;
    logic [7:0] r_running, n_running;
    logic [7:0] r_current, n_current;
    logic [6:0] r_first,   n_first;
    logic       r_sysex,   n_sysex;

    // Result stage
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [3:0] r_chan;
    logic [6:0] r_note;
    logic [6:0] r_vel;

    logic       out_free;
    logic       proc_en;
    logic       in_take;
    logic       res_valid;
    logic [1:0] res_kind;
    logic [6:0] res_note;
    logic [6:0] res_vel;
    logic [6:0] data;
    logic [7:0] cur_type;
    logic [7:0] cur_chan;

    assign out_free   = !r_out_valid || i_out_ready;
    assign proc_en    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    assign data     = r_in_byte[6:0];
    assign cur_type = r_current & mnep_pkg::ST_TYPE_MASK;
    assign cur_chan = r_current & mnep_pkg::ST_CHAN_MASK;

    always_comb begin
        n_phase   = r_phase;
        n_running = r_running;
        n_current = r_current;
        n_first   = r_first;
        n_sysex   = r_sysex;
        res_valid = 1'b0;
        res_kind  = mnep_pkg::EV_NOTE_OFF;
        res_note  = 7'd0;
        res_vel   = 7'd0;

        if (r_sysex) begin
            if (r_in_byte == mnep_pkg::ST_SYSEX_END) begin
                n_sysex = 1'b0;
            end
        end else if (r_in_byte[7]) begin
            if (r_in_byte == mnep_pkg::ST_SYSEX_START) begin
                n_sysex   = 1'b1;
                n_running = 8'd0;
            end else if (r_in_byte >= mnep_pkg::ST_REALTIME_LO) begin
                // real-time: no effect
            end else if (r_in_byte >= mnep_pkg::ST_SYSEX_START) begin
                n_running = 8'd0;   // system common, phase kept
            end else begin
                n_current = r_in_byte;
                n_running = r_in_byte;
                n_phase   = PH_DATA1;
            end
        end else begin
            case (r_phase)
                PH_DATA1: begin
                    n_first = data;
                    n_phase = mnep_pkg::single_data_kind(r_current) ? PH_STATUS : PH_DATA2;
                end
                PH_DATA2: begin
                    n_phase = PH_STATUS;
                    if (cur_type == mnep_pkg::TY_NOTE_OFF) begin
                        res_valid = 1'b1;
                        res_note  = r_first;
                    end else if (cur_type == mnep_pkg::TY_NOTE_ON) begin
                        res_valid = 1'b1;
                        res_note  = r_first;
                        if (data != 7'd0) begin
                            res_kind = mnep_pkg::EV_NOTE_ON;
                            res_vel  = data;
                        end
                    end else if (cur_type == mnep_pkg::TY_CONTROL &&
                                 r_first == mnep_pkg::CC_ALL_NOTES_OFF) begin
                        res_valid = 1'b1;
                        res_kind  = mnep_pkg::EV_ALL_NOTES_OFF;
                    end
                end
                default: begin
                    // data byte in status phase: reuse running status if any
                    if (r_running != 8'd0) begin
                        n_current = r_running;
                        n_first   = data;
                        n_phase   = mnep_pkg::single_data_kind(r_running) ?
                                    PH_STATUS : PH_DATA2;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_STATUS;
            r_running   <= 8'd0;
            r_current   <= 8'd0;
            r_first     <= 7'd0;
            r_sysex     <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= proc_en && res_valid;
            end
            if (proc_en) begin
                r_phase   <= n_phase;
                r_running <= n_running;
                r_current <= n_current;
                r_first   <= n_first;
                r_sysex   <= n_sysex;
            end
        end
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
        if (proc_en) begin
            r_kind <= res_kind;
            r_chan <= cur_chan[3:0];
            r_note <= res_note;
            r_vel  <= res_vel;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_channel    = r_chan;
    assign o_note       = r_note;
    assign o_velocity   = r_vel;

    // Bytes inside SysEx never produce a result
    a_sysex_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_en && r_sysex |=> !o_out_valid)
        else $error("result produced inside SysEx");

    // Status bytes never produce a result
    a_status_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_en && r_in_byte[7] |=> !o_out_valid)
        else $error("result produced by a status byte");

    // All-notes-off carries zero note and velocity
    a_all_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == mnep_pkg::EV_ALL_NOTES_OFF
        |-> o_note == 7'd0 && o_velocity == 7'd0)
        else $error("all-notes-off with nonzero note or velocity");

    // Note-on always has a nonzero velocity; other kinds have none
    a_velocity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_kind == mnep_pkg::EV_NOTE_ON) == (o_velocity != 7'd0))
        else $error("velocity does not match event kind");

    // Parser never leaves the three legal phases
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_en |=> r_phase == PH_STATUS || r_phase == PH_DATA1 || r_phase == PH_DATA2)
        else $error("illegal parse phase");

endmodule
